/* sv/lrm_pkg.sv */
// Shared types and constants for the label region moments block.
// No dependencies; imported by lrm_pos and label_region_moments.
package lrm_pkg;

	localparam int PIX_W  = 8;
	localparam int CFG_W  = 13;
	localparam int ADDR_W = 2;
	localparam int SIZE_W = 16;

	localparam int W_AREA = 25;
	localparam int W_X    = 35;
	localparam int W_Y    = 35;
	localparam int W_XX   = 47;
	localparam int W_XY   = 46;
	localparam int W_YY   = 47;

	localparam logic [ADDR_W-1:0] REG_MASK_LABEL   = 2'd0;
	localparam logic [ADDR_W-1:0] REG_FRAME_WIDTH  = 2'd1;
	localparam logic [ADDR_W-1:0] REG_FRAME_HEIGHT = 2'd2;

	localparam logic [CFG_W-1:0] FRAME_SIZE_RESET = 13'd4096;

	typedef struct packed {
		logic row_end;
		logic frame_end;
	} pos_flags_t;

endpackage

/* sv/lrm_pos.sv */
// Raster position counters with frame size clamping.
// Depends on lrm_pkg for the size width and the flag struct.
module lrm_pos import lrm_pkg::*; #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096,
	localparam int CW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1,
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic [CFG_W-1:0] frame_width,
	input  logic [CFG_W-1:0] frame_height,
	output logic [CW-1:0]    x,
	output logic [RW-1:0]    y,
	output pos_flags_t       flags
);

	logic [CW-1:0]     col_q;
	logic [RW-1:0]     row_q;
	logic [SIZE_W-1:0] w_eff;
	logic [SIZE_W-1:0] h_eff;
	logic [SIZE_W-1:0] fw_ext;
	logic [SIZE_W-1:0] fh_ext;

	assign fw_ext = SIZE_W'(frame_width);
	assign fh_ext = SIZE_W'(frame_height);

	always_comb begin
		if (fw_ext == '0) begin
			w_eff = SIZE_W'(1);
		end else if (fw_ext > SIZE_W'(MAX_WIDTH)) begin
			w_eff = SIZE_W'(MAX_WIDTH);
		end else begin
			w_eff = fw_ext;
		end
		if (fh_ext == '0) begin
			h_eff = SIZE_W'(1);
		end else if (fh_ext > SIZE_W'(MAX_HEIGHT)) begin
			h_eff = SIZE_W'(MAX_HEIGHT);
		end else begin
			h_eff = fh_ext;
		end
	end

	assign x = col_q;
	assign y = row_q;
	assign flags.row_end   = (SIZE_W'(col_q) + SIZE_W'(1)) >= w_eff;
	assign flags.frame_end = flags.row_end && ((SIZE_W'(row_q) + SIZE_W'(1)) >= h_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (!flags.row_end) begin
				col_q <= col_q + CW'(1);
			end else begin
				col_q <= '0;
				if (flags.frame_end) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + RW'(1);
				end
			end
		end
	end

endmodule

/* sv/label_region_moments.sv */
// Second order raw moments of one label over a raster mask frame.
// Result path: a frame's last accepted pixel moves through stage 1 and stage 2 into the output register.
// Throughput: one pixel per cycle; the pipeline holds only when a frame result
// reaches the output register while the previous result is still waiting.
// Reset: counters, sums and valid bits clear; label resets to 0, sizes to 4096.
// Depends on lrm_pkg and lrm_pos.
module label_region_moments import lrm_pkg::*; #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [ADDR_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]  cfg_wdata,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [PIX_W-1:0]  mask_pixel,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [W_AREA-1:0] area,
	output logic [W_X-1:0]    sum_x,
	output logic [W_Y-1:0]    sum_y,
	output logic [W_XX-1:0]   sum_xx,
	output logic [W_XY-1:0]   sum_xy,
	output logic [W_YY-1:0]   sum_yy
);

	localparam int CW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

	logic [PIX_W-1:0] mask_label_q;
	logic [CFG_W-1:0] frame_width_q;
	logic [CFG_W-1:0] frame_height_q;

	logic          advance;
	logic          accept;
	logic [CW-1:0] x_cur;
	logic [RW-1:0] y_cur;
	pos_flags_t    flags_cur;

	logic          v_s1, match_s1, last_s1;
	logic [CW-1:0] x_s1;
	logic [RW-1:0] y_s1;

	logic             v_s2, last_s2, one_s2;
	logic [CW-1:0]    x_s2;
	logic [RW-1:0]    y_s2;
	logic [2*CW-1:0]  xx_s2;
	logic [CW+RW-1:0] xy_s2;
	logic [2*RW-1:0]  yy_s2;

	logic [W_AREA-1:0] acc_area_q, nxt_area;
	logic [W_X-1:0]    acc_x_q, nxt_x;
	logic [W_Y-1:0]    acc_y_q, nxt_y;
	logic [W_XX-1:0]   acc_xx_q, nxt_xx;
	logic [W_XY-1:0]   acc_xy_q, nxt_xy;
	logic [W_YY-1:0]   acc_yy_q, nxt_yy;
	logic              out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_label_q   <= '0;
			frame_width_q  <= FRAME_SIZE_RESET;
			frame_height_q <= FRAME_SIZE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_MASK_LABEL:   mask_label_q   <= cfg_wdata[PIX_W-1:0];
				REG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata;
				REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Hold the whole pipe only when a frame result would overwrite a waiting one.
	assign advance  = !(out_valid_q && !out_ready && v_s2 && last_s2);
	assign in_ready = advance;
	assign accept   = in_valid && advance;

	lrm_pos #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_pos (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (accept),
		.frame_width  (frame_width_q),
		.frame_height (frame_height_q),
		.x            (x_cur),
		.y            (y_cur),
		.flags        (flags_cur)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (advance) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			match_s1 <= (mask_pixel == mask_label_q);
			last_s1  <= flags_cur.frame_end;
			x_s1     <= x_cur;
			y_s1     <= y_cur;

			last_s2 <= last_s1;
			one_s2  <= match_s1;
			x_s2    <= match_s1 ? x_s1 : '0;
			y_s2    <= match_s1 ? y_s1 : '0;
			xx_s2   <= match_s1 ? (2*CW)'(x_s1) * (2*CW)'(x_s1) : '0;
			xy_s2   <= match_s1 ? (CW+RW)'(x_s1) * (CW+RW)'(y_s1) : '0;
			yy_s2   <= match_s1 ? (2*RW)'(y_s1) * (2*RW)'(y_s1) : '0;
		end
	end

	always_comb begin
		nxt_area = acc_area_q + W_AREA'(one_s2);
		nxt_x    = acc_x_q + W_X'(x_s2);
		nxt_y    = acc_y_q + W_Y'(y_s2);
		nxt_xx   = acc_xx_q + W_XX'(xx_s2);
		nxt_xy   = acc_xy_q + W_XY'(xy_s2);
		nxt_yy   = acc_yy_q + W_YY'(yy_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_area_q  <= '0;
			acc_x_q     <= '0;
			acc_y_q     <= '0;
			acc_xx_q    <= '0;
			acc_xy_q    <= '0;
			acc_yy_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (advance && v_s2) begin
				if (last_s2) begin
					acc_area_q  <= '0;
					acc_x_q     <= '0;
					acc_y_q     <= '0;
					acc_xx_q    <= '0;
					acc_xy_q    <= '0;
					acc_yy_q    <= '0;
					out_valid_q <= 1'b1;
				end else begin
					acc_area_q <= nxt_area;
					acc_x_q    <= nxt_x;
					acc_y_q    <= nxt_y;
					acc_xx_q   <= nxt_xx;
					acc_xy_q   <= nxt_xy;
					acc_yy_q   <= nxt_yy;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && v_s2 && last_s2) begin
			area   <= nxt_area;
			sum_x  <= nxt_x;
			sum_y  <= nxt_y;
			sum_xx <= nxt_xx;
			sum_xy <= nxt_xy;
			sum_yy <= nxt_yy;
		end
	end

	assign out_valid = out_valid_q;

	a_stall_only_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a waiting result");

	a_result_from_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(v_s2 && last_s2))
		else $error("result raised without a frame end");

	a_counters_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && flags_cur.frame_end |=> x_cur == '0 && y_cur == '0)
		else $error("position not cleared after frame end");

endmodule

/* sim/label_region_moments_tb.sv */
// Testbench for label_region_moments: streams raster mask frames through the block
// and checks each emitted moment set against an in-bench accumulator model.
// Depends on lrm_pkg and the label_region_moments RTL.
module label_region_moments_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lrm_pkg::*;

	localparam int MAX_W = 4096;
	localparam int MAX_H = 4096;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_ITEMS = 1100;
	localparam logic [ADDR_W-1:0] REG_SPARE = 2'd3;

	typedef struct packed {
		logic [W_AREA-1:0] area;
		logic [W_X-1:0]    sum_x;
		logic [W_Y-1:0]    sum_y;
		logic [W_XX-1:0]   sum_xx;
		logic [W_XY-1:0]   sum_xy;
		logic [W_YY-1:0]   sum_yy;
	} moments_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_W-1:0]  cfg_wdata = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [PIX_W-1:0]  mask_pixel = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [W_AREA-1:0] area;
	logic [W_X-1:0]    sum_x;
	logic [W_Y-1:0]    sum_y;
	logic [W_XX-1:0]   sum_xx;
	logic [W_XY-1:0]   sum_xy;
	logic [W_YY-1:0]   sum_yy;

	label_region_moments #(
		.MAX_WIDTH(MAX_W),
		.MAX_HEIGHT(MAX_H)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mask_pixel(mask_pixel),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.area(area),
		.sum_x(sum_x),
		.sum_y(sum_y),
		.sum_xx(sum_xx),
		.sum_xy(sum_xy),
		.sum_yy(sum_yy)
	);

	logic [PIX_W-1:0] label_cfg = '0;
	logic [CFG_W-1:0] width_cfg = FRAME_SIZE_RESET;
	logic [CFG_W-1:0] height_cfg = FRAME_SIZE_RESET;
	longint unsigned  col_pos = 0;
	longint unsigned  row_pos = 0;
	longint unsigned  acc_area = 0;
	longint unsigned  acc_x = 0;
	longint unsigned  acc_y = 0;
	longint unsigned  acc_xx = 0;
	longint unsigned  acc_xy = 0;
	longint unsigned  acc_yy = 0;

	moments_t         pending_moments[$];
	logic [PIX_W-1:0] pixel_q[$];
	int               pixels_in_flight = 0;
	int               mismatch_cnt = 0;
	int               cycle_cnt = 0;
	int               src_gap = 0;
	int               snk_gap = 0;
	bit               idle_on = 1'b1;
	bit               pix_taken = 1'b0;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic longint unsigned fit_size(logic [CFG_W-1:0] v, longint unsigned limit);
		if (v == '0)
			return 1;
		if (v > limit)
			return limit;
		return v;
	endfunction

	function automatic void accumulate_pixel(logic [PIX_W-1:0] pix);
		longint unsigned w;
		longint unsigned h;
		moments_t m;
		w = fit_size(width_cfg, MAX_W);
		h = fit_size(height_cfg, MAX_H);
		if (pix == label_cfg) begin
			acc_area += 1;
			acc_x += col_pos;
			acc_y += row_pos;
			acc_xx += col_pos * col_pos;
			acc_xy += col_pos * row_pos;
			acc_yy += row_pos * row_pos;
		end
		if (col_pos + 1 < w) begin
			col_pos++;
		end else begin
			col_pos = 0;
			if (row_pos + 1 < h) begin
				row_pos++;
			end else begin
				m.area = W_AREA'(acc_area);
				m.sum_x = W_X'(acc_x);
				m.sum_y = W_Y'(acc_y);
				m.sum_xx = W_XX'(acc_xx);
				m.sum_xy = W_XY'(acc_xy);
				m.sum_yy = W_YY'(acc_yy);
				pending_moments.push_back(m);
				row_pos = 0;
				acc_area = 0;
				acc_x = 0;
				acc_y = 0;
				acc_xx = 0;
				acc_xy = 0;
				acc_yy = 0;
			end
		end
	endfunction

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			mismatch_cnt++;
			$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : monitor_blk
		moments_t want;
		if (arst_n) begin
			pix_taken = in_valid && in_ready;
			if (in_valid && in_ready) begin
				accumulate_pixel(mask_pixel);
				pixels_in_flight--;
			end
			if (out_valid && out_ready) begin
				if (pending_moments.size() == 0) begin
					mismatch_cnt++;
					$display("%0t ns: result with no frame pending, expected none, got area %0d",
						$time, area);
				end else begin
					want = pending_moments.pop_front();
					check_field("area", want.area, area);
					check_field("sum_x", want.sum_x, sum_x);
					check_field("sum_y", want.sum_y, sum_y);
					check_field("sum_xx", want.sum_xx, sum_xx);
					check_field("sum_xy", want.sum_xy, sum_xy);
					check_field("sum_yy", want.sum_yy, sum_yy);
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n && !(in_valid && !pix_taken)) begin
			if (src_gap > 0) begin
				in_valid <= 1'b0;
				src_gap--;
			end else if (pixel_q.size() != 0) begin
				in_valid <= 1'b1;
				mask_pixel <= pixel_q.pop_front();
				if (idle_on && $urandom_range(0, 5) == 0)
					src_gap = $urandom_range(1, 3);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (snk_gap > 0) begin
				out_ready <= 1'b0;
				snk_gap--;
			end else begin
				out_ready <= 1'b1;
				if (idle_on && $urandom_range(0, 4) == 0)
					snk_gap = $urandom_range(1, 3);
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("label_region_moments: mismatch");
			$finish;
		end
	end

	task automatic send_pixel(logic [PIX_W-1:0] p);
		pixel_q.push_back(p);
		pixels_in_flight++;
	endtask

	task automatic send_stream(int n, int hit_pct);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < hit_pct)
				send_pixel(label_cfg);
			else
				send_pixel(PIX_W'($urandom_range(0, 255)));
		end
	endtask

	task automatic write_reg(logic [ADDR_W-1:0] addr, logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= data;
		case (addr)
			REG_MASK_LABEL: label_cfg = data[PIX_W-1:0];
			REG_FRAME_WIDTH: width_cfg = data;
			REG_FRAME_HEIGHT: height_cfg = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic settle();
		while (pixels_in_flight != 0 || pending_moments.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic logic [CFG_W-1:0] random_size(int top);
		if ($urandom_range(0, 15) == 0)
			return '0;
		if ($urandom_range(0, 31) == 0)
			return CFG_W'($urandom_range(4097, 8191));
		return CFG_W'($urandom_range(1, top));
	endfunction

	initial begin : stimulus
		int random_items;
		int n;
		int hit_pct;
		longint unsigned span;
		random_items = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_reg(REG_MASK_LABEL, 13'd0);
		write_reg(REG_FRAME_WIDTH, 13'd3);
		write_reg(REG_FRAME_HEIGHT, 13'd2);
		write_reg(REG_SPARE, 13'h1FFF);
		send_pixel(8'd0);
		send_pixel(8'd255);
		send_pixel(8'd0);
		send_pixel(8'd0);
		send_pixel(8'd1);
		send_pixel(8'd0);
		settle();

		// zero sizes act as one: every pixel closes a frame
		write_reg(REG_MASK_LABEL, 13'h1FFF);
		write_reg(REG_FRAME_WIDTH, 13'd0);
		write_reg(REG_FRAME_HEIGHT, 13'd0);
		send_pixel(8'd255);
		send_pixel(8'd254);
		settle();

		write_reg(REG_MASK_LABEL, 13'h1EA5);
		write_reg(REG_FRAME_WIDTH, 13'd2);
		write_reg(REG_FRAME_HEIGHT, 13'd2);
		send_pixel(8'hA5);
		send_pixel(8'h5A);
		send_pixel(8'hA5);
		send_pixel(8'hA5);
		settle();

		// shrink the frame and change the label mid-frame
		write_reg(REG_MASK_LABEL, 13'd0);
		write_reg(REG_FRAME_WIDTH, 13'd4);
		write_reg(REG_FRAME_HEIGHT, 13'd3);
		repeat (5) send_pixel(8'd0);
		settle();
		write_reg(REG_FRAME_WIDTH, 13'd2);
		write_reg(REG_FRAME_HEIGHT, 13'd2);
		write_reg(REG_MASK_LABEL, 13'd7);
		send_pixel(8'd7);
		settle();
		send_pixel(8'd7);
		send_pixel(8'd0);
		send_pixel(8'd7);
		send_pixel(8'd7);
		settle();

		// oversize sizes clamp; shrink mid-frame to close a long row and a tall column
		write_reg(REG_MASK_LABEL, 13'd255);
		write_reg(REG_FRAME_WIDTH, 13'h1FFF);
		write_reg(REG_FRAME_HEIGHT, 13'h1FFF);
		send_stream(200, 75);
		settle();
		write_reg(REG_FRAME_WIDTH, 13'd1);
		write_reg(REG_FRAME_HEIGHT, 13'd1);
		send_pixel(8'd255);
		settle();
		write_reg(REG_FRAME_HEIGHT, 13'h1FFF);
		send_stream(200, 75);
		settle();
		write_reg(REG_FRAME_HEIGHT, 13'd1);
		send_pixel(8'd255);
		settle();

		while (random_items < RANDOM_ITEMS) begin
			idle_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 2) != 0)
				write_reg(REG_MASK_LABEL, CFG_W'($urandom_range(0, 8191)));
			if ($urandom_range(0, 2) != 0)
				write_reg(REG_FRAME_WIDTH, random_size(9));
			if ($urandom_range(0, 2) != 0)
				write_reg(REG_FRAME_HEIGHT, random_size(6));
			if ($urandom_range(0, 15) == 0)
				write_reg(REG_SPARE, CFG_W'($urandom_range(0, 8191)));
			span = 3 * fit_size(width_cfg, MAX_W) * fit_size(height_cfg, MAX_H);
			n = (span > 300) ? $urandom_range(1, 300) : $urandom_range(1, int'(span));
			case ($urandom_range(0, 4))
				0: hit_pct = 0;
				1: hit_pct = 30;
				2: hit_pct = 60;
				3: hit_pct = 90;
				default: hit_pct = 100;
			endcase
			send_stream(n, hit_pct);
			random_items += n;
			settle();
		end

		idle_on = 1'b0;
		write_reg(REG_FRAME_WIDTH, 13'd5);
		write_reg(REG_FRAME_HEIGHT, 13'd4);
		send_stream(100, 60);
		settle();

		if (mismatch_cnt == 0)
			$display("label_region_moments: match");
		else
			$display("label_region_moments: mismatch");
		$finish;
	end

endmodule

/* files.f */
sv/lrm_pkg.sv
sv/lrm_pos.sv
sv/label_region_moments.sv
sim/label_region_moments_tb.sv
